>>> hdl/ffba_pkg.sv
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    // request kinds
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    typedef logic [2:0] status_t;

    localparam status_t ST_REUSED   = 3'd0;
    localparam status_t ST_APPENDED = 3'd1;
    localparam status_t ST_ZERO     = 3'd2;
    localparam status_t ST_OOM      = 3'd3;
    localparam status_t ST_FREED    = 3'd4;
    localparam status_t ST_SHRUNK   = 3'd5;
    localparam status_t ST_NULL     = 3'd6;
    localparam status_t ST_UNKNOWN  = 3'd7;

    typedef struct packed {
        logic        mode;
        logic [31:0] request_size;
        logic [31:0] user_address;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        status_t     status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic        is_free;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } state_t;

endpackage

>>> hdl/ffba_table.sv
module ffba_table (
    input  logic                     clk,
    input  logic [ffba_pkg::IDX_W-1:0] rd_addr,
    output ffba_pkg::entry_t         rd_data,
    input  logic                     wr_en,
    input  logic [ffba_pkg::IDX_W-1:0] wr_addr,
    input  ffba_pkg::entry_t         wr_data
);

    ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/first_fit_block_allocator.sv
// First-fit heap block allocator.
//
// Request channel (req_valid / req_stall / req): one transaction is either an
// allocate (mode 0, request_size) or a release (mode 1, user_address). A
// transaction is taken when req_valid is high and req_stall is low; the block
// holds req_stall high while it works on a request, so one request is in
// flight at a time.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response
// transaction per request, in request order. A response sits in an output
// register; while the receiver stalls it is held, and the block still takes
// and works on the next request, parking its result until the register frees.
// A request that needs no table walk (zero size, null release, empty table) skips
// it and goes straight to the append or the response. Otherwise the block table is
// walked one entry per cycle through the single read port of the table memory,
// up to entry_count entries (MAX_BLOCKS worst case, 64).
// The next request is taken the cycle after a response is loaded, so the block
// takes no new request before it is through with the last one.
// Configuration (cfg_we / cfg_index / cfg_data) is to be written only while idle;
// the block does not enforce it. Reset clears the block count and the break offset
// and restores the register defaults (base 0, limit 65536); table needs no clear.
module first_fit_block_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffba_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam int IDX_W = ffba_pkg::IDX_W;
    localparam int CNT_W = ffba_pkg::CNT_W;

    ffba_pkg::state_t state_reg, state_next;

    ffba_pkg::req_t    req_reg, req_next;
    ffba_pkg::rsp_t    res_reg, res_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [31:0]       break_offset_reg, break_offset_next;
    logic [31:0]       heap_base_reg;
    logic [31:0]       heap_limit_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    ffba_pkg::rsp_t    rsp_data_reg, rsp_data_next;

    // table memory port
    logic [IDX_W-1:0]  rd_addr;
    ffba_pkg::entry_t  rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ffba_pkg::entry_t  wr_data;

    logic              accept;
    logic              rsp_load;
    logic [31:0]       entry_user_addr;
    logic              alloc_hit;
    logic              rel_hit;
    logic              hit;
    logic              is_last;
    logic [33:0]       new_break;
    logic              no_room;

    ffba_table u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req_stall = (state_reg != ffba_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_load  = (state_reg == ffba_pkg::S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Read entry 0 as the request arrives, then the next entry every scan cycle
    assign rd_addr = (state_reg == ffba_pkg::S_IDLE) ? '0 : scan_idx_reg + IDX_W'(1);

    // Compare the entry that just came out of the table
    assign entry_user_addr = heap_base_reg + rd_data.offset + 32'(ffba_pkg::HEADER_BYTES);
    assign alloc_hit = rd_data.is_free && (rd_data.size >= req_reg.request_size);
    assign rel_hit   = (entry_user_addr == req_reg.user_address);
    assign hit       = (req_reg.mode == ffba_pkg::MODE_RELEASE) ? rel_hit : alloc_hit;
    assign is_last   = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == entry_count_reg;

    // Break after an append, kept wide so the limit check cannot wrap
    assign new_break = {2'b00, break_offset_reg} + 34'(ffba_pkg::HEADER_BYTES)
                     + {2'b00, req_reg.request_size};
    assign no_room   = (entry_count_reg == CNT_W'(ffba_pkg::MAX_BLOCKS))
                     || (new_break > {2'b00, heap_limit_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == ffba_pkg::MODE_ALLOC)
                    begin
                        if (req.request_size == '0)
                            state_next = ffba_pkg::S_DONE;
                        else if (entry_count_reg == '0)
                            state_next = ffba_pkg::S_APPEND;
                        else
                            state_next = ffba_pkg::S_SCAN;
                    end
                    else
                    begin
                        if (req.user_address == '0 || entry_count_reg == '0)
                            state_next = ffba_pkg::S_DONE;
                        else
                            state_next = ffba_pkg::S_SCAN;
                    end
                end
            end
            ffba_pkg::S_SCAN:
            begin
                if (hit)
                    state_next = ffba_pkg::S_DONE;
                else if (is_last)
                    state_next = (req_reg.mode == ffba_pkg::MODE_ALLOC) ?
                                 ffba_pkg::S_APPEND : ffba_pkg::S_DONE;
            end
            ffba_pkg::S_APPEND:
            begin
                state_next = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_DONE:
            begin
                if (rsp_load)
                    state_next = ffba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and table write-back
    always_comb
    begin
        req_next          = req_reg;
        res_next          = res_reg;
        scan_idx_next     = scan_idx_reg;
        entry_count_next  = entry_count_reg;
        break_offset_next = break_offset_reg;
        wr_en             = 1'b0;
        wr_addr           = scan_idx_reg;
        wr_data           = rd_data;
        case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next                = req;
                    scan_idx_next           = '0;
                    res_next.result_address = '0;
                    if (req.mode == ffba_pkg::MODE_ALLOC)
                        res_next.status = ffba_pkg::ST_ZERO;
                    else if (req.user_address == '0)
                        res_next.status = ffba_pkg::ST_NULL;
                    else
                        res_next.status = ffba_pkg::ST_UNKNOWN;
                end
            end
            ffba_pkg::S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (hit)
                begin
                    if (req_reg.mode == ffba_pkg::MODE_ALLOC)
                    begin
                        // reuse whole, take the free mark off
                        wr_en                   = 1'b1;
                        wr_data.is_free         = 1'b0;
                        res_next.result_address = entry_user_addr;
                        res_next.status         = ffba_pkg::ST_REUSED;
                    end
                    else if (is_last)
                    begin
                        // drop the last block and pull the break back
                        entry_count_next        = CNT_W'(scan_idx_reg);
                        break_offset_next       = rd_data.offset;
                        res_next.result_address = '0;
                        res_next.status         = ffba_pkg::ST_SHRUNK;
                    end
                    else
                    begin
                        wr_en                   = 1'b1;
                        wr_data.is_free         = 1'b1;
                        res_next.result_address = '0;
                        res_next.status         = ffba_pkg::ST_FREED;
                    end
                end
                else if (is_last)
                begin
                    res_next.result_address = '0;
                    res_next.status         = ffba_pkg::ST_UNKNOWN;
                end
            end
            ffba_pkg::S_APPEND:
            begin
                if (no_room)
                begin
                    res_next.result_address = '0;
                    res_next.status         = ffba_pkg::ST_OOM;
                end
                else
                begin
                    wr_en                   = 1'b1;
                    wr_addr                 = entry_count_reg[IDX_W-1:0];
                    wr_data.offset          = break_offset_reg;
                    wr_data.size            = req_reg.request_size;
                    wr_data.is_free         = 1'b0;
                    entry_count_next        = entry_count_reg + CNT_W'(1);
                    break_offset_next       = new_break[31:0];
                    res_next.result_address = heap_base_reg + break_offset_reg
                                            + 32'(ffba_pkg::HEADER_BYTES);
                    res_next.status         = ffba_pkg::ST_APPENDED;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: drop on take, load the parked result when free
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ffba_pkg::S_IDLE;
            entry_count_reg  <= '0;
            break_offset_reg <= '0;
            rsp_valid_reg    <= 1'b0;
            heap_base_reg    <= 32'd0;
            heap_limit_reg   <= 32'd65536;
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            break_offset_reg <= break_offset_next;
            rsp_valid_reg    <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ffba_pkg::CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                    ffba_pkg::CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        scan_idx_reg <= scan_idx_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(ffba_pkg::MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffba_pkg::S_SCAN) |-> (CNT_W'(scan_idx_reg) < entry_count_reg))
        else $error("scan index past last block");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ffba_pkg::S_SCAN || state_reg == ffba_pkg::S_APPEND))
        else $error("table written outside scan or append");

    a_break_moves_on_work: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(break_offset_reg) |->
            ($past(state_reg) == ffba_pkg::S_SCAN || $past(state_reg) == ffba_pkg::S_APPEND))
        else $error("break moved outside scan or append");

endmodule
